FILE: design/egb_pkg.sv
`timescale 1ns / 1ps

package egb_pkg;

  // operand and coefficient widths
  localparam int unsigned OPERAND_WIDTH = 31;
  localparam int unsigned COEF_WIDTH    = OPERAND_WIDTH + 1;
  localparam int unsigned CNT_WIDTH     = $clog2(OPERAND_WIDTH + 1);

  // request payload
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] operand_a;
    logic [OPERAND_WIDTH-1:0] operand_b;
  } egb_in_t;

  // result payload
  typedef struct packed {
    logic [OPERAND_WIDTH-1:0]      gcd_value;
    logic signed [COEF_WIDTH-1:0]  coef_a;
    logic signed [COEF_WIDTH-1:0]  coef_b;
  } egb_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic mul;
    logic upd;
    logic out_load;
  } egb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic r1_zero;
    logic div_done;
  } egb_status_t;

endpackage

FILE: design/egb_divider.sv
`timescale 1ns / 1ps

module egb_divider (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [egb_pkg::OPERAND_WIDTH-1:0]     dividend_i,
  input  logic [egb_pkg::OPERAND_WIDTH-1:0]     divisor_i,
  output logic                                  done_o,
  output logic [egb_pkg::OPERAND_WIDTH-1:0]     quotient_o,
  output logic [egb_pkg::OPERAND_WIDTH-1:0]     remainder_o
);

  localparam int unsigned W = egb_pkg::OPERAND_WIDTH;

  logic [W-1:0]                   quo_q, quo_d;
  logic [W-1:0]                   rem_q, rem_d;
  logic [W-1:0]                   dsr_q, dsr_d;
  logic [egb_pkg::CNT_WIDTH-1:0]  cnt_q, cnt_d;
  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [W:0]                     shifted;
  logic [W:0]                     diff;
  logic                           qbit;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dsr_q};
    qbit    = ~diff[W];
  end

  // iteration control and data
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = egb_pkg::CNT_WIDTH'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[W-2:0], qbit};
      rem_d = qbit ? diff[W-1:0] : shifted[W-1:0];
      cnt_d = cnt_q - egb_pkg::CNT_WIDTH'(1);
      if (cnt_q == egb_pkg::CNT_WIDTH'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: design/egb_datapath.sv
`timescale 1ns / 1ps

module egb_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  egb_pkg::egb_cmd_t    cmd_i,
  output egb_pkg::egb_status_t status_o,
  input  egb_pkg::egb_in_t     in_data_i,
  output egb_pkg::egb_out_t    out_data_o
);

  localparam int unsigned W = egb_pkg::OPERAND_WIDTH;
  localparam int unsigned C = egb_pkg::COEF_WIDTH;

  logic [W-1:0]      r0_q, r1_q;
  logic [C-1:0]      s0_q, s1_q, t0_q, t1_q;
  logic [C-1:0]      ps_q, pt_q;
  logic              a_first_q;
  egb_pkg::egb_out_t out_q;
  logic              a_first;
  logic [W-1:0]      div_quo;
  logic [W-1:0]      div_rem;
  logic              div_done;
  logic [C-1:0]      ps_full, pt_full;

  // shared quotient unit
  egb_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (r0_q),
    .divisor_i   (r1_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // larger operand takes the dividend role, tie goes to b
  assign a_first = in_data_i.operand_a > in_data_i.operand_b;

  // quotient times the newer coefficients, low bits only since values wrap
  always_comb begin
    ps_full = {1'b0, div_quo} * s1_q;
    pt_full = {1'b0, div_quo} * t1_q;
  end

  // remainder and coefficient registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_first_q <= a_first;
      r0_q      <= a_first ? in_data_i.operand_a : in_data_i.operand_b;
      r1_q      <= a_first ? in_data_i.operand_b : in_data_i.operand_a;
      s0_q      <= C'(1);
      s1_q      <= '0;
      t0_q      <= '0;
      t1_q      <= C'(1);
    end else if (cmd_i.upd) begin
      r0_q <= r1_q;
      r1_q <= div_rem;
      s0_q <= s1_q;
      s1_q <= s0_q - ps_q;
      t0_q <= t1_q;
      t1_q <= t0_q - pt_q;
    end
    if (cmd_i.mul) begin
      ps_q <= ps_full;
      pt_q <= pt_full;
    end
  end

  // result register, coefficients put back in operand order
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.gcd_value <= r0_q;
      out_q.coef_a    <= a_first_q ? s0_q : t0_q;
      out_q.coef_b    <= a_first_q ? t0_q : s0_q;
    end
  end

  assign status_o.r1_zero  = (r1_q == '0);
  assign status_o.div_done = div_done;
  assign out_data_o        = out_q;

  // division only started with a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> r1_q != '0)
    else $error("division started with zero divisor");

  // remainder is below the divisor when it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> div_rem < r1_q)
    else $error("remainder not below divisor");

  // result only taken once the remainder chain has ended
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> r1_q == '0)
    else $error("result taken before last step");

endmodule

FILE: design/egb_ctrl.sv
`timescale 1ns / 1ps

module egb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  egb_pkg::egb_status_t status_i,
  output egb_pkg::egb_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_UPD   = 6'b010000,
    S_DONE  = 6'b100000
  } egb_state_e;

  egb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.r1_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_CHECK;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // divider finishes only while it is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == S_DIV)
    else $error("divider done outside wait state");

  // never overwrite a result that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten");

  // an accepted request always starts with the zero check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_CHECK)
    else $error("request not started");

endmodule

FILE: design/extended_gcd_bezout.sv
// Euclid steps per request: none when the smaller operand is zero, at most 44 for 31-bit operands
// each step runs the zero check, the division, the multiply and the coefficient update in turn
// throughput: one request at a time; the next is taken the cycle after the result is loaded
// each step is set by the shared restoring divider, one quotient bit per cycle
// reset: rst_ni asynchronous active low, returns to idle with no result pending
`timescale 1ns / 1ps

module extended_gcd_bezout (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  egb_pkg::egb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output egb_pkg::egb_out_t out_data_o
);

  egb_pkg::egb_cmd_t    cmd;
  egb_pkg::egb_status_t status;

  // sequencer
  egb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // remainders, coefficients and result register
  egb_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: tb/egb_checker.sv
`timescale 1ns / 1ps

module egb_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_stall_i,
  input  egb_pkg::egb_in_t  req_data_i,
  input  logic              res_valid_i,
  input  logic              res_stall_i,
  input  egb_pkg::egb_out_t res_data_i,
  output int unsigned       err_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  // results still owed by the block, oldest first
  egb_pkg::egb_out_t bezout_q[$];

  // extended euclid on the larger/smaller pair, coefficients wrap in 64 bits
  function automatic egb_pkg::egb_out_t bezout_of(egb_pkg::egb_in_t req);
    logic [63:0]       r0, r1, s0, s1, t0, t1;
    logic [63:0]       q, nr, ns, nt;
    logic              a_larger;
    egb_pkg::egb_out_t res;
    a_larger = req.operand_a > req.operand_b;
    r0 = a_larger ? 64'(req.operand_a) : 64'(req.operand_b);
    r1 = a_larger ? 64'(req.operand_b) : 64'(req.operand_a);
    s0 = 64'd1;
    s1 = 64'd0;
    t0 = 64'd0;
    t1 = 64'd1;
    while (r1 != 64'd0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      ns = s0 - q * s1;
      nt = t0 - q * t1;
      r0 = r1;
      r1 = nr;
      s0 = s1;
      s1 = ns;
      t0 = t1;
      t1 = nt;
    end
    res.gcd_value = r0[egb_pkg::OPERAND_WIDTH-1:0];
    // s belongs to the larger operand, t to the smaller
    res.coef_a = a_larger ? s0[egb_pkg::COEF_WIDTH-1:0] : t0[egb_pkg::COEF_WIDTH-1:0];
    res.coef_b = a_larger ? t0[egb_pkg::COEF_WIDTH-1:0] : s0[egb_pkg::COEF_WIDTH-1:0];
    return res;
  endfunction

  // results are matched before new requests are queued
  always @(posedge clk_i) begin : monitor
    egb_pkg::egb_out_t want;
    if (!rst_ni) begin
      bezout_q.delete();
      err_count_o = 0;
      pending_o   = 0;
      checked_o   = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (bezout_q.size() == 0) begin
          $error("result with no request outstanding: gcd %0d", res_data_i.gcd_value);
          err_count_o++;
        end else begin
          want = bezout_q.pop_front();
          checked_o++;
          if (res_data_i.gcd_value !== want.gcd_value) begin
            $error("gcd_value: expected %0d, got %0d", want.gcd_value,
                   res_data_i.gcd_value);
            err_count_o++;
          end
          if (res_data_i.coef_a !== want.coef_a) begin
            $error("coef_a: expected %0d, got %0d", $signed(want.coef_a),
                   $signed(res_data_i.coef_a));
            err_count_o++;
          end
          if (res_data_i.coef_b !== want.coef_b) begin
            $error("coef_b: expected %0d, got %0d", $signed(want.coef_b),
                   $signed(res_data_i.coef_b));
            err_count_o++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        bezout_q.push_back(bezout_of(req_data_i));
      end
      pending_o = bezout_q.size();
    end
  end

endmodule

FILE: tb/extended_gcd_bezout_tb.sv
`timescale 1ns / 1ps

module extended_gcd_bezout_tb;

  localparam int unsigned DIRECTED       = 22;
  localparam int unsigned RANDOM_ITEMS   = 880;
  localparam int unsigned HOLD_AT        = 40;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 2000;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [egb_pkg::OPERAND_WIDTH-1:0] OP_MAX = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  egb_pkg::egb_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  egb_pkg::egb_out_t out_data_o;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned sent;

  // zero cases, ties, exact divisors, extremes and the longest fibonacci chain
  logic [egb_pkg::OPERAND_WIDTH-1:0] dir_a [DIRECTED] = '{
    0, 0, 987654, 77777, OP_MAX, 7, 1000000, 1, OP_MAX, OP_MAX, 1134903170,
    1836311903, 1431655765, 240, 46, 0, OP_MAX, 1, 1073741824, 2147483646, 1, 0
  };
  logic [egb_pkg::OPERAND_WIDTH-1:0] dir_b [DIRECTED] = '{
    0, 12345, 0, 77777, OP_MAX, 91, 1000, OP_MAX, 1, OP_MAX - 1, 1836311903,
    1134903170, 715827882, 46, 240, OP_MAX, 0, 1, 536870912, 1073741823, 0, 1
  };

  extended_gcd_bezout DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  egb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_stall_i (in_stall_o),
    .req_data_i  (in_data_i),
    .res_valid_i (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_data_i  (out_data_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // reset once at the start
  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // offer one request, with a random gap outside burst phases
  task automatic send_request(input egb_pkg::egb_in_t req);
    int unsigned gap;
    gap = (((sent / 50) % 3) == 1) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sent++;
    @(negedge clk_i);
  endtask

  // operand pairs of several shapes
  function automatic egb_pkg::egb_in_t random_operands();
    egb_pkg::egb_in_t req;
    logic [63:0]      raw;
    logic [63:0]      x;
    logic [63:0]      y;
    logic [63:0]      g;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9)) inside
      [0:4]: begin
        req.operand_a = raw[egb_pkg::OPERAND_WIDTH-1:0];
        req.operand_b = raw[32+egb_pkg::OPERAND_WIDTH-1:32];
      end
      [5:6]: begin
        req.operand_a = egb_pkg::OPERAND_WIDTH'($urandom_range(0, 255));
        req.operand_b = egb_pkg::OPERAND_WIDTH'($urandom_range(0, 255));
      end
      7: begin
        // one operand an exact multiple of the other
        x = 64'($urandom_range(1, 65535));
        y = x * 64'($urandom_range(0, 32767));
        req.operand_a = raw[0] ? x[egb_pkg::OPERAND_WIDTH-1:0] : y[egb_pkg::OPERAND_WIDTH-1:0];
        req.operand_b = raw[0] ? y[egb_pkg::OPERAND_WIDTH-1:0] : x[egb_pkg::OPERAND_WIDTH-1:0];
      end
      8: begin
        // shared factor
        g = 64'($urandom_range(1, 1023));
        x = g * 64'($urandom_range(0, 2097151));
        y = g * 64'($urandom_range(0, 2097151));
        req.operand_a = x[egb_pkg::OPERAND_WIDTH-1:0];
        req.operand_b = y[egb_pkg::OPERAND_WIDTH-1:0];
      end
      default: begin
        // zero, one, max or equal operands
        case (raw[1:0])
          2'd0: req.operand_a = '0;
          2'd1: req.operand_a = egb_pkg::OPERAND_WIDTH'(1);
          2'd2: req.operand_a = OP_MAX;
          default: req.operand_a = raw[egb_pkg::OPERAND_WIDTH-1:0];
        endcase
        case (raw[3:2])
          2'd0: req.operand_b = '0;
          2'd1: req.operand_b = OP_MAX;
          2'd2: req.operand_b = req.operand_a;
          default: req.operand_b = raw[32+egb_pkg::OPERAND_WIDTH-1:32];
        endcase
      end
    endcase
    return req;
  endfunction

  // request side, end of run and verdict
  initial begin : request_source
    egb_pkg::egb_in_t req;
    sent       = 0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    for (int i = 0; i < DIRECTED; i++) begin
      req.operand_a = dir_a[i];
      req.operand_b = dir_b[i];
      send_request(req);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_request(random_operands());
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d requests (%0d directed, %0d random), %0d results checked",
             sent, DIRECTED, RANDOM_ITEMS, checked);
    $display("result side held off for %0d cycles once to back up the request side",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stall per result, burst phases, one long hold-off
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken       = 0;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else if (((taken / 40) % 3) == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 7);
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      taken++;
    end
  end

  // give up when neither channel moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no handshake for %0d cycles, %0d results outstanding", WATCHDOG_LIMIT,
             pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: extended_gcd_bezout.f
design/egb_pkg.sv
design/egb_divider.sv
design/egb_datapath.sv
design/egb_ctrl.sv
design/extended_gcd_bezout.sv
tb/egb_checker.sv
tb/extended_gcd_bezout_tb.sv
